>>> rtl/core/thermistor_adc_to_temperature_top_macros.svh
// assertion helpers, clocked on the rising edge with active-low reset
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_TOP_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_TOP_MACROS_SVH

// same-cycle implication
`define TAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tat check failed");

// next-cycle implication
`define TAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tat check failed");

`endif

>>> rtl/core/tat_pkg.sv
`default_nettype none
package tat_pkg;

    localparam int LW = 20;
    localparam int FW = 16;
    localparam int QW = 17;
    localparam int RW = 58;
    localparam int DW = 41;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OPEN  = 2'd1,
        ST_SHORT = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_PULLUP = 2'd0,
        CFG_BETA   = 2'd1,
        CFG_T0     = 2'd2,
        CFG_R0     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic    vld;
        t_status st;
    } t_tag;

    typedef struct packed {
        logic [30:0]   m;
        logic [4:0]    n;
        logic [FW-1:0] frac;
    } t_lg;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] q;
    } t_dv;

    function automatic t_lg lg_norm(input logic [LW-1:0] x);
        t_lg         r;
        logic [4:0]  n;
        logic [LW-1:0] xv;
        xv = (x == '0) ? LW'(1) : x;
        n  = '0;
        for (int i = 0; i < LW; i++) begin
            if (xv[i]) begin
                n = 5'(i);
            end
        end
        r.n    = n;
        r.m    = 31'(31'(xv) << (5'd30 - n));
        r.frac = '0;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tat_lg_cell.sv
`default_nettype none
module tat_lg_cell #(
    parameter int BIT = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tat_pkg::t_tag    i_tag,
    input  wire tat_pkg::t_lg     i_lg [4],
    output tat_pkg::t_tag         o_tag,
    output tat_pkg::t_lg          o_lg [4]
);

    tat_pkg::t_tag r_tag;
    tat_pkg::t_lg  r_lg [4];
    tat_pkg::t_lg  n_lg [4];

    always_comb begin
        logic [61:0] sq;
        for (int l = 0; l < 4; l++) begin
            sq      = 62'(i_lg[l].m) * 62'(i_lg[l].m);
            n_lg[l] = i_lg[l];
            if (sq[61]) begin
                n_lg[l].m         = sq[61:31];
                n_lg[l].frac[BIT] = 1'b1;
            end else begin
                n_lg[l].m = sq[60:30];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else begin
            r_tag.vld <= i_tag.vld;
        end
        r_tag.st <= i_tag.st;
        r_lg     <= n_lg;
    end

    assign o_tag = r_tag;
    assign o_lg  = r_lg;

endmodule
`default_nettype wire

>>> rtl/core/tat_div_cell.sv
`default_nettype none
module tat_div_cell #(
    parameter int K = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tat_pkg::t_tag i_tag,
    input  wire tat_pkg::t_dv  i_dv,
    output tat_pkg::t_tag      o_tag,
    output tat_pkg::t_dv       o_dv
);

    tat_pkg::t_tag r_tag;
    tat_pkg::t_dv  r_dv;
    tat_pkg::t_dv  n_dv;
    logic [tat_pkg::RW-1:0] sub;

    always_comb begin
        sub  = tat_pkg::RW'(i_dv.den) << K;
        n_dv = i_dv;
        if (i_dv.rem >= sub) begin
            n_dv.rem  = i_dv.rem - sub;
            n_dv.q[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else begin
            r_tag.vld <= i_tag.vld;
        end
        r_tag.st <= i_tag.st;
        r_dv     <= n_dv;
    end

    assign o_tag = r_tag;
    assign o_dv  = r_dv;

endmodule
`default_nettype wire

>>> rtl/core/thermistor_adc_to_temperature_top.sv
// an accepted request passes the input register, the log2 squaring cells, the combine
// registers tg_s to tg_f, dv_tag[0], the quotient cells and the output register
// throughput: one request per cycle, no stalls; the pipeline depth is set by
// 16 log2 squaring cells and 17 restoring quotient cells in line
// reset: synchronous, active low; clears the pipeline and loads default registers,
// busy and cfg ready stay high/low until the cycle after reset; results never stall
`default_nettype none
`include "thermistor_adc_to_temperature_top_macros.svh"
module thermistor_adc_to_temperature_top #(
    parameter int ADC_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [11:0]        i_adc_code,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [19:0]        i_cfg_data,
    output logic                    o_done,
    output logic signed [16:0]      o_temperature_centi_c,
    output logic [1:0]              o_status
);

    localparam int LW = tat_pkg::LW;
    localparam logic [LW-1:0] FULL = LW'((1 << ADC_BITS) - 1);
    localparam logic signed [30:0] C_LN2 = 31'sd744261118;
    localparam logic signed [53:0] C_RND = 54'sd1073741823;

    logic        r_busy;
    logic [19:0] r_pullup;
    logic [15:0] r_beta;
    logic [15:0] r_t0;
    logic [19:0] r_r0;
    logic [19:0] pu;
    logic [15:0] bk;
    logic [15:0] t0;
    logic [19:0] r0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_pullup <= 20'd10000;
            r_beta   <= 16'd3950;
            r_t0     <= 16'd29815;
            r_r0     <= 20'd10000;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (tat_pkg::t_cfg_idx'(i_cfg_index))
                    tat_pkg::CFG_PULLUP: r_pullup <= i_cfg_data;
                    tat_pkg::CFG_BETA:   r_beta   <= i_cfg_data[15:0];
                    tat_pkg::CFG_T0:     r_t0     <= i_cfg_data[15:0];
                    tat_pkg::CFG_R0:     r_r0     <= i_cfg_data;
                endcase
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign pu = (r_pullup == '0) ? 20'd1 : r_pullup;
    assign bk = (r_beta == '0) ? 16'd1 : r_beta;
    assign t0 = (r_t0 == '0) ? 16'd1 : r_t0;
    assign r0 = (r_r0 == '0) ? 20'd1 : r_r0;

    // input stage: classify and normalize the four log operands
    logic [LW-1:0]  code;
    tat_pkg::t_tag  n_tag0;
    tat_pkg::t_tag  lg_tag [17];
    tat_pkg::t_lg   lg_d   [17][4];

    assign code = LW'(i_adc_code) & FULL;

    always_comb begin
        n_tag0.vld = i_start && !r_busy;
        if (code == '0) begin
            n_tag0.st = tat_pkg::ST_OPEN;
        end else if (code == FULL) begin
            n_tag0.st = tat_pkg::ST_SHORT;
        end else begin
            n_tag0.st = tat_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            lg_tag[0].vld <= 1'b0;
        end else begin
            lg_tag[0].vld <= n_tag0.vld;
        end
        lg_tag[0].st <= n_tag0.st;
        lg_d[0][0]   <= tat_pkg::lg_norm(pu);
        lg_d[0][1]   <= tat_pkg::lg_norm(FULL - code);
        lg_d[0][2]   <= tat_pkg::lg_norm(code);
        lg_d[0][3]   <= tat_pkg::lg_norm(r0);
    end

    for (genvar g = 0; g < 16; g++) begin : g_lg
        tat_lg_cell #(.BIT(15 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (lg_tag[g]),
            .i_lg    (lg_d[g]),
            .o_tag   (lg_tag[g + 1]),
            .o_lg    (lg_d[g + 1])
        );
    end

    // log combine, scale to natural log, build numerator and denominator
    logic [20:0]        lgv [4];
    logic signed [22:0] r_s;
    logic signed [53:0] r_prod;
    logic signed [53:0] adj;
    logic signed [23:0] r_lnq;
    logic signed [40:0] r_tl;
    logic [31:0]        r_tb;
    logic [22:0]        b100;
    logic signed [41:0] r_den;
    logic [54:0]        r_num;
    logic [55:0]        r_dvd;
    logic [40:0]        r_dvs;
    tat_pkg::t_tag      tg_s, tg_p, tg_l, tg_d, tg_e, tg_f;
    tat_pkg::t_tag      dv_tag [18];
    tat_pkg::t_dv       dv_d   [18];
    logic               sat_f;
    logic               ovf;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            lgv[l] = {lg_d[16][l].n, lg_d[16][l].frac};
        end
        adj   = r_prod + (r_prod[53] ? C_RND : 54'sd0);
        b100  = 23'(bk) * 23'd100;
        sat_f = r_den[41] || (r_den == '0);
        ovf   = {2'b0, r_dvd} >= {r_dvs, 17'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            tg_s.vld      <= 1'b0;
            tg_p.vld      <= 1'b0;
            tg_l.vld      <= 1'b0;
            tg_d.vld      <= 1'b0;
            tg_e.vld      <= 1'b0;
            tg_f.vld      <= 1'b0;
            dv_tag[0].vld <= 1'b0;
        end else begin
            tg_s.vld      <= lg_tag[16].vld;
            tg_p.vld      <= tg_s.vld;
            tg_l.vld      <= tg_p.vld;
            tg_d.vld      <= tg_l.vld;
            tg_e.vld      <= tg_d.vld;
            tg_f.vld      <= tg_e.vld;
            dv_tag[0].vld <= tg_f.vld;
        end
        tg_s.st <= lg_tag[16].st;
        tg_p.st <= tg_s.st;
        tg_l.st <= tg_p.st;
        tg_d.st <= tg_l.st;
        tg_e.st <= tg_d.st;
        tg_f.st <= (sat_f && tg_e.st == tat_pkg::ST_OK) ? tat_pkg::ST_SAT : tg_e.st;
        dv_tag[0].st <= (ovf && tg_f.st == tat_pkg::ST_OK) ? tat_pkg::ST_SAT : tg_f.st;

        r_s    <= $signed({2'b0, lgv[0]}) + $signed({2'b0, lgv[1]})
                - $signed({2'b0, lgv[2]}) - $signed({2'b0, lgv[3]});
        r_prod <= r_s * C_LN2;
        r_lnq  <= adj[53:30];
        r_tl   <= $signed({1'b0, t0}) * r_lnq;
        r_tb   <= 32'(t0) * 32'(bk);
        r_den  <= $signed({3'b0, b100, 16'b0}) + $signed({r_tl[40], r_tl});
        r_num  <= {39'(r_tb) * 39'd100, 16'b0};
        r_dvd  <= {1'b0, r_num} + {15'b0, r_den[41:1]};
        r_dvs  <= r_den[40:0];
        dv_d[0].rem <= {2'b0, r_dvd};
        dv_d[0].den <= r_dvs;
        dv_d[0].q   <= '0;
    end

    for (genvar g = 0; g < 17; g++) begin : g_dv
        tat_div_cell #(.K(16 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (dv_tag[g]),
            .i_dv    (dv_d[g]),
            .o_tag   (dv_tag[g + 1]),
            .o_dv    (dv_d[g + 1])
        );
    end

    // output stage
    logic signed [17:0] tc;
    logic               r_done;
    logic signed [16:0] r_temp;
    logic [1:0]         r_st;
    logic signed [16:0] n_temp;
    tat_pkg::t_status   n_st;

    always_comb begin
        tc = $signed({1'b0, dv_d[17].q}) - 18'sd27315;
        unique case (dv_tag[17].st) inside
            tat_pkg::ST_OPEN, tat_pkg::ST_SHORT: begin
                n_temp = '0;
                n_st   = dv_tag[17].st;
            end
            tat_pkg::ST_SAT: begin
                n_temp = 17'sd50000;
                n_st   = tat_pkg::ST_SAT;
            end
            default: begin
                if (tc > 18'sd50000) begin
                    n_temp = 17'sd50000;
                    n_st   = tat_pkg::ST_SAT;
                end else begin
                    n_temp = tc[16:0];
                    n_st   = tat_pkg::ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_tag[17].vld;
        end
        r_temp <= n_temp;
        r_st   <= n_st;
    end

    assign o_done                = r_done;
    assign o_temperature_centi_c = r_temp;
    assign o_status              = r_st;

    `TAT_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n,
        o_done && (o_status == tat_pkg::ST_OPEN || o_status == tat_pkg::ST_SHORT),
        o_temperature_centi_c == 17'sd0)
    `TAT_ASSERT_IMP(a_sat_bound, i_clk, i_rst_n, o_done && o_status == tat_pkg::ST_SAT,
        o_temperature_centi_c == 17'sd50000 || o_temperature_centi_c == -17'sd27315)
    `TAT_ASSERT_IMP(a_ok_range, i_clk, i_rst_n, o_done && o_status == tat_pkg::ST_OK,
        o_temperature_centi_c >= -17'sd27315 && o_temperature_centi_c <= 17'sd50000)
    `TAT_ASSERT_NXT(a_done_follows, i_clk, i_rst_n, dv_tag[17].vld, o_done)

endmodule
`default_nettype wire

>>> verif/thermistor_adc_to_temperature_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module thermistor_adc_to_temperature_top_tb;

    localparam int FULL_CODE = 4095;
    localparam int LATENCY = 42;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 1900;

    typedef struct packed {
        logic signed [16:0] temp;
        tat_pkg::t_status   st;
    } t_reading;

    typedef struct packed {
        logic              is_cfg;
        logic              wait_drain;
        tat_pkg::t_cfg_idx idx;
        logic [19:0]       data;
        logic [11:0]       code;
        logic              no_gap;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [11:0] i_adc_code = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_cfg_ready;
    logic        o_done;
    logic signed [16:0] o_temperature_centi_c;
    logic [1:0]  o_status;

    thermistor_adc_to_temperature_top u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (i_start),
        .o_busy                (o_busy),
        .i_adc_code            (i_adc_code),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_done                (o_done),
        .o_temperature_centi_c (o_temperature_centi_c),
        .o_status              (o_status)
    );

    t_req       pending_reqs[$];
    t_reading   expected_readings[$];
    logic [19:0] pullup_reg, r0_reg;
    logic [15:0] beta_reg, t0_reg;
    int error_count = 0;
    int readings_seen = 0;
    int configs_done = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int drain_wait = 0;
    bit stim_done = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint log2_q16(longint x);
        longint m;
        longint frac;
        int n;
        frac = 0;
        n = 0;
        if (x == 0) x = 1;
        while (n < 31 && (x >> (n + 1)) != 0) n++;
        m = x << (30 - n);
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'sd1 << 31)) begin
                m = m >> 1;
                frac = frac | (64'sd1 << (16 - i));
            end
        end
        return (longint'(n) << 16) | frac;
    endfunction

    function automatic t_reading predict_temperature(logic [11:0] code_in);
        t_reading r;
        longint code, pu, b, t0, r0, s, lnq, num, den, tk, t;
        code = code_in;
        pu = (pullup_reg == 0) ? 1 : pullup_reg;
        b = (beta_reg == 0) ? 1 : beta_reg;
        t0 = (t0_reg == 0) ? 1 : t0_reg;
        r0 = (r0_reg == 0) ? 1 : r0_reg;
        r.st = tat_pkg::ST_OK;
        if (code == 0) begin
            r.temp = '0;
            r.st = tat_pkg::ST_OPEN;
            return r;
        end
        if (code == FULL_CODE) begin
            r.temp = '0;
            r.st = tat_pkg::ST_SHORT;
            return r;
        end
        s = log2_q16(pu) + log2_q16(FULL_CODE - code) - log2_q16(code) - log2_q16(r0);
        lnq = (s * 64'sd744261118) / (64'sd1 << 30);
        num = 100 * t0 * b * 65536;
        den = 100 * b * 65536 + t0 * lnq;
        if (den <= 0) begin
            t = 50000;
            r.st = tat_pkg::ST_SAT;
        end else begin
            tk = (num + den / 2) / den;
            t = tk - 27315;
            if (t > 50000) begin
                t = 50000;
                r.st = tat_pkg::ST_SAT;
            end else if (t < -27315) begin
                t = -27315;
                r.st = tat_pkg::ST_SAT;
            end
        end
        r.temp = 17'(t);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void push_code(logic [11:0] c, logic no_gap);
        t_req q;
        q = '0;
        q.code = c;
        q.no_gap = no_gap;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_cfg(tat_pkg::t_cfg_idx idx, logic [19:0] d);
        t_req q;
        q = '0;
        q.is_cfg = 1'b1;
        q.wait_drain = 1'b1;
        q.idx = idx;
        q.data = d;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_pause();
        t_req q;
        q = '0;
        q.wait_drain = 1'b1;
        q.is_cfg = 1'b1;
        q.idx = tat_pkg::CFG_R0;
        q.data = 20'hFFFFF;
        q.code = 12'hFFF;
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_codes(int count, bit calm);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: push_code(12'($urandom_range(0, 3)), calm);
                1: push_code(12'($urandom_range(4092, 4095)), calm);
                2: push_code(12'(1 << $urandom_range(0, 11)), calm);
                default: push_code(12'($urandom_range(0, 4095)), calm);
            endcase
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_req head;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                expected_readings.push_back(predict_temperature(i_adc_code));
                idle_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (tat_pkg::t_cfg_idx'(i_cfg_index))
                    tat_pkg::CFG_PULLUP: pullup_reg = i_cfg_data;
                    tat_pkg::CFG_BETA:   beta_reg = i_cfg_data[15:0];
                    tat_pkg::CFG_T0:     t0_reg = i_cfg_data[15:0];
                    tat_pkg::CFG_R0:     r0_reg = i_cfg_data;
                    default: ;
                endcase
                configs_done++;
                idle_cycles = 0;
            end
            if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || (!i_start && !i_cfg_valid))
            begin
                if (pending_reqs.size() == 0) begin
                    i_start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                    stim_done = 1;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else begin
                    head = pending_reqs[0];
                    if (head.wait_drain && (expected_readings.size() != 0 ||
                        drain_wait < LATENCY + 4)) begin
                        if (expected_readings.size() != 0) drain_wait = 0;
                        else drain_wait++;
                        i_start <= 1'b0;
                        i_cfg_valid <= 1'b0;
                    end else begin
                        void'(pending_reqs.pop_front());
                        drain_wait = 0;
                        if (head.is_cfg && head.code == 12'hFFF && head.data == 20'hFFFFF)
                        begin
                            // bare drain pause, nothing to drive
                            i_start <= 1'b0;
                            i_cfg_valid <= 1'b0;
                        end else if (head.is_cfg) begin
                            i_start <= 1'b0;
                            i_cfg_valid <= 1'b1;
                            i_cfg_index <= head.idx;
                            i_cfg_data <= head.data;
                        end else begin
                            i_cfg_valid <= 1'b0;
                            i_start <= 1'b1;
                            i_adc_code <= head.code;
                            if (!head.no_gap && $urandom_range(0, 5) == 0)
                                gap_left = $urandom_range(1, 5);
                        end
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (o_done) begin
                readings_seen++;
                idle_cycles = 0;
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected result, status", o_status, -1);
                end else begin
                    want = expected_readings.pop_front();
                    if (o_temperature_centi_c !== want.temp)
                        report_mismatch("temperature", o_temperature_centi_c, want.temp);
                    if (o_status !== want.st)
                        report_mismatch("status", o_status, want.st);
                end
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        logic [19:0] ohm_vals[4];
        logic [15:0] w16_vals[4];
        pullup_reg = 20'd10000;
        beta_reg = 16'd3950;
        t0_reg = 16'd29815;
        r0_reg = 20'd10000;

        // directed: field extremes at reset values
        push_code(12'd0, 0);
        push_code(12'd4095, 0);
        push_code(12'd1, 0);
        push_code(12'd4094, 0);
        push_code(12'd2048, 0);
        push_code(12'd2047, 0);
        push_code(12'hAAA, 0);
        push_code(12'h555, 0);
        // zero registers and extremes force saturation paths
        push_cfg(tat_pkg::CFG_PULLUP, 20'd0);
        push_cfg(tat_pkg::CFG_R0, 20'hFFFFF);
        push_cfg(tat_pkg::CFG_BETA, 20'd1);
        push_code(12'd1, 0);
        push_code(12'd4094, 0);
        push_code(12'd2000, 0);
        push_cfg(tat_pkg::CFG_PULLUP, 20'hFFFFF);
        push_cfg(tat_pkg::CFG_R0, 20'd1);
        push_cfg(tat_pkg::CFG_T0, 20'hFFFF);
        push_code(12'd1, 0);
        push_code(12'd4094, 0);
        push_cfg(tat_pkg::CFG_T0, 20'd0);
        push_cfg(tat_pkg::CFG_BETA, 20'hFFFF);
        push_code(12'd100, 0);
        push_code(12'd4000, 0);

        ohm_vals = '{20'd1, 20'd10000, 20'd100000, 20'hFFFFF};
        w16_vals = '{16'd1, 16'd3950, 16'd29815, 16'hFFFF};
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                push_cfg(tat_pkg::CFG_PULLUP, 20'd10000);
                push_cfg(tat_pkg::CFG_BETA, 20'd3950);
                push_cfg(tat_pkg::CFG_T0, 20'd29815);
                push_cfg(tat_pkg::CFG_R0, 20'd10000);
            end else begin
                push_cfg(tat_pkg::CFG_PULLUP, $urandom_range(0, 3) == 0 ?
                    ohm_vals[$urandom_range(0, 3)] : 20'($urandom_range(1000, 200000)));
                push_cfg(tat_pkg::CFG_BETA, $urandom_range(0, 3) == 0 ?
                    20'(w16_vals[$urandom_range(0, 3)]) : 20'($urandom_range(2000, 5000)));
                push_cfg(tat_pkg::CFG_T0, $urandom_range(0, 3) == 0 ?
                    20'(w16_vals[$urandom_range(0, 3)]) : 20'($urandom_range(25000, 35000)));
                push_cfg(tat_pkg::CFG_R0, $urandom_range(0, 3) == 0 ?
                    20'($urandom_range(0, 20'hFFFFF)) : 20'($urandom_range(1000, 200000)));
            end
            push_codes(NUM_RANDOM / 12 - 10, 0);
            if (phase == 5) push_pause();
            push_codes(10, 0);
        end
        push_codes(40, 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results outstanding",
                    expected_readings.size());
                $display("thermistor_adc_to_temperature_top_tb: FAIL");
                $finish;
            end
            if (stim_done && pending_reqs.size() == 0 && expected_readings.size() == 0)
            begin
                repeat (LATENCY + 8) @(posedge i_clk);
                $display("covered %0d temperature results over %0d register writes,",
                    readings_seen, configs_done);
                $display("including open, short, saturation and zero-register cases");
                if (error_count == 0 && expected_readings.size() == 0) begin
                    $display("thermistor_adc_to_temperature_top_tb: PASS");
                end else begin
                    $display("thermistor_adc_to_temperature_top_tb: FAIL");
                end
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
